// ===== hdl/gfa_pkg.sv =====
// gfa_pkg: shared types, constants and the inverse table for the gf(2^8) unit
// field polynomial 0x11d, generator 2; no dependencies
package gfa_pkg;

   localparam int ELEM_W = 8;
   localparam logic [ELEM_W:0] FIELD_POLY = 9'h11D;
   localparam int FIELD_SIZE = 1 << ELEM_W;
   localparam int FIELD_ORDER_M1 = FIELD_SIZE - 1;
   localparam int CELL_COUNT = ELEM_W;
   localparam int LATENCY = CELL_COUNT + 1;

   typedef logic [ELEM_W-1:0] elem_type;
   typedef logic [FIELD_SIZE-1:0][ELEM_W-1:0] table_type;

   typedef enum logic [1:0] {
      KIND_MUL = 2'd0,
      KIND_DIV = 2'd1,
      KIND_INV = 2'd2,
      KIND_MAC = 2'd3
   } kind_type;

   // data handed from one cell to the next
   typedef struct packed {
      logic     valid;
      logic     zdiv;
      logic     last;
      elem_type acc;
      elem_type m;
      elem_type y;
   } cell_type;

   // multiply by the generator, reduced by the field polynomial
   function automatic elem_type xtime(elem_type x);
      elem_type s;
      s = {x[ELEM_W-2:0], 1'b0};
      return x[ELEM_W-1] ? (s ^ FIELD_POLY[ELEM_W-1:0]) : s;
   endfunction

   // inverse table built from powers of the generator
   function automatic table_type gen_inv_table();
      table_type exp_t;
      table_type inv_t;
      elem_type  e;
      int        i;
      e = elem_type'(1);
      for (i = 0; i < FIELD_SIZE; i++) begin
         exp_t[i] = elem_type'(1);
         inv_t[i] = '0;
      end
      for (i = 0; i < FIELD_ORDER_M1; i++) begin
         exp_t[i] = e;
         e = xtime(e);
      end
      for (i = 0; i < FIELD_ORDER_M1; i++) begin
         inv_t[exp_t[i]] = (i == 0) ? exp_t[0] : exp_t[FIELD_ORDER_M1 - i];
      end
      inv_t[0] = '0;
      return inv_t;
   endfunction

   localparam table_type INV_TABLE = gen_inv_table();

endpackage

// ===== hdl/gfa_prep.sv =====
// gfa_prep: head cell, decodes the operation and loads the multiply chain
// depends on gfa_pkg (kind codes, cell_type, inverse table)
module gfa_prep
   import gfa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  logic [1:0] kind,
   input  elem_type operand_a,
   input  elem_type operand_b,
   input  elem_type accum_in,
   input  logic     last_in,
   output cell_type cell_out
);

   cell_type cell_ff;
   cell_type cell_in;
   elem_type inv_a;
   elem_type inv_b;

   assign inv_a = INV_TABLE[operand_a];
   assign inv_b = INV_TABLE[operand_b];

   always_comb begin
      cell_in       = '0;
      cell_in.valid = accept;
      cell_in.last  = last_in;
      case (kind_type'(kind))
         KIND_MUL: begin
            cell_in.m = operand_a;
            cell_in.y = operand_b;
         end
         KIND_DIV: begin
            cell_in.m    = operand_a;
            cell_in.y    = inv_b;
            cell_in.zdiv = (operand_b == '0);
         end
         KIND_INV: begin
            cell_in.m    = elem_type'(1);
            cell_in.y    = inv_a;
            cell_in.zdiv = (operand_a == '0);
         end
         KIND_MAC: begin
            cell_in.m   = operand_a;
            cell_in.y   = operand_b;
            cell_in.acc = accum_in;
         end
         default: begin
            cell_in.m = operand_a;
            cell_in.y = operand_b;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

// ===== hdl/gfa_cell.sv =====
// gfa_cell: one shift-and-add step of the field multiply
// depends on gfa_pkg (cell_type, xtime)
module gfa_cell
   import gfa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cell_type cell_in,
   output cell_type cell_out
);

   cell_type cell_ff;
   cell_type step_in;

   always_comb begin
      step_in     = cell_in;
      step_in.acc = cell_in.acc ^ (cell_in.y[0] ? cell_in.m : '0);
      step_in.m   = xtime(cell_in.m);
      step_in.y   = cell_in.y >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff <= step_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

// ===== hdl/gf256_arith_unit.sv =====
// gf256_arith_unit: gf(2^8) multiply, divide, inverse and multiply-accumulate
// depends on gfa_pkg, gfa_prep, gfa_cell
//
//   channel    handshake                  payload
//   request    start / busy               req_kind, req_operand_a, req_operand_b,
//                                         req_accum_in, req_last_in
//   response   rsp_valid (one cycle)      rsp_result, rsp_zero_divide, rsp_last_out
//
// one request per cycle; each answer comes from its request through the registered decode cell
// and then eight multiply cells, one per multiplier bit
// busy is high only during reset; the chain never stalls and the receiver cannot stall it
// synchronous reset clears the valid bit of every cell
module gf256_arith_unit
   import gfa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_operand_a,
   input  logic [7:0] req_operand_b,
   input  logic [7:0] req_accum_in,
   input  logic       req_last_in,
   output logic       rsp_valid,
   output logic [7:0] rsp_result,
   output logic       rsp_zero_divide,
   output logic       rsp_last_out
);

   cell_type chain [CELL_COUNT+1];
   logic     accept;

   assign busy   = reset;
   assign accept = start && !busy;

   gfa_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_kind),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .accum_in  (req_accum_in),
      .last_in   (req_last_in),
      .cell_out  (chain[0])
   );

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      gfa_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   assign rsp_valid       = chain[CELL_COUNT].valid;
   assign rsp_result      = chain[CELL_COUNT].acc;
   assign rsp_zero_divide = chain[CELL_COUNT].zdiv;
   assign rsp_last_out    = chain[CELL_COUNT].last;

   // every response traces back to a request
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("response without request");

   // every request gets its response
   a_req_gets_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("request lost");

   // a zero divisor always yields zero
   a_zdiv_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_divide) |-> (rsp_result == '0))
      else $error("zero divide with nonzero result");

   // multiply by a zero first operand gives zero without the flag
   a_mul_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && (kind_type'(req_kind) == KIND_MUL) && (req_operand_a == '0))
      |-> ##LATENCY ((rsp_result == '0) && !rsp_zero_divide))
      else $error("multiply by zero");

endmodule
